FILE: hdl/json_token_scanner_macros.svh
// Assertion helpers for the JSON token scanner
`ifndef JSON_TOKEN_SCANNER_MACROS_SVH
`define JSON_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define JTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define JTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

    // Token event codes
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_STR_START = 4'd1,
        EV_STR_CHAR  = 4'd2,
        EV_STR_END   = 4'd3,
        EV_NUM_CHAR  = 4'd4,
        EV_NUM_END   = 4'd5,
        EV_OPEN_OBJ  = 4'd6,
        EV_CLOSE_OBJ = 4'd7,
        EV_OPEN_ARR  = 4'd8,
        EV_CLOSE_ARR = 4'd9,
        EV_COLON     = 4'd10,
        EV_COMMA     = 4'd11,
        EV_TRUE      = 4'd12,
        EV_FALSE     = 4'd13,
        EV_NULL      = 4'd14,
        EV_ILLEGAL   = 4'd15
    } event_t;

    localparam int CH_W = 21;
    typedef logic [CH_W-1:0] char_t;

    // Character codes
    localparam char_t CH_SPACE    = 21'h20;
    localparam char_t CH_TAB      = 21'h09;
    localparam char_t CH_LF       = 21'h0A;
    localparam char_t CH_CR       = 21'h0D;
    localparam char_t CH_QUOTE    = 21'h22;
    localparam char_t CH_BSLASH   = 21'h5C;
    localparam char_t CH_SLASH    = 21'h2F;
    localparam char_t CH_LBRACE   = 21'h7B;
    localparam char_t CH_RBRACE   = 21'h7D;
    localparam char_t CH_LBRACKET = 21'h5B;
    localparam char_t CH_RBRACKET = 21'h5D;
    localparam char_t CH_COLON    = 21'h3A;
    localparam char_t CH_COMMA    = 21'h2C;
    localparam char_t CH_MINUS    = 21'h2D;
    localparam char_t CH_PLUS     = 21'h2B;
    localparam char_t CH_DOT      = 21'h2E;
    localparam char_t CH_ZERO     = 21'h30;
    localparam char_t CH_NINE     = 21'h39;
    localparam char_t CH_LC_A     = 21'h61;
    localparam char_t CH_LC_B     = 21'h62;
    localparam char_t CH_LC_E     = 21'h65;
    localparam char_t CH_LC_F     = 21'h66;
    localparam char_t CH_LC_L     = 21'h6C;
    localparam char_t CH_LC_N     = 21'h6E;
    localparam char_t CH_LC_R     = 21'h72;
    localparam char_t CH_LC_S     = 21'h73;
    localparam char_t CH_LC_T     = 21'h74;
    localparam char_t CH_LC_U     = 21'h75;
    localparam char_t CH_UC_A     = 21'h41;
    localparam char_t CH_UC_E     = 21'h45;
    localparam char_t CH_UC_F     = 21'h46;

    function automatic logic is_ws(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input char_t c);
        return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F))
            || ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    // Expected next letter for the literal states (after t/tr/tru, f..fals, n/nu/nul)
    function automatic char_t lit_expect(input logic [4:0] st);
        char_t c;
        case (st)
            5'd7:    c = CH_LC_R;
            5'd8:    c = CH_LC_U;
            5'd9:    c = CH_LC_E;
            5'd10:   c = CH_LC_A;
            5'd11:   c = CH_LC_L;
            5'd12:   c = CH_LC_S;
            5'd13:   c = CH_LC_E;
            5'd14:   c = CH_LC_U;
            5'd15:   c = CH_LC_L;
            5'd16:   c = CH_LC_L;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/json_token_scanner.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata from bit 0 up)              Ends
// s_*       in   tdata[20:0] ch                            one character
// m_*       out  tdata[3:0] event_res, [24:4] content_char tlast = last of a character
//
// One character per cycle unless m_tready stalls; a number closed by a brace,
// bracket or comma gives two results and holds the input while the single
// output register drains the second. A character is registered at input and output.
// rst_n clears the scanner state and all valid flags; payload is not reset.
// A stall on m_tready holds the output and backs up through s_tready.

`include "json_token_scanner_macros.svh"

module json_token_scanner
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] ch, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] event_res, [24:4] content_char, [31:25] zero
    output logic        m_tlast
);

    typedef enum logic [4:0] {
        ST_GENERAL  = 5'd0,
        ST_STRING   = 5'd1,
        ST_ESCAPE   = 5'd2,
        ST_HEX1     = 5'd3,
        ST_HEX2     = 5'd4,
        ST_HEX3     = 5'd5,
        ST_HEX4     = 5'd6,
        ST_T1       = 5'd7,
        ST_T2       = 5'd8,
        ST_T3       = 5'd9,
        ST_F1       = 5'd10,
        ST_F2       = 5'd11,
        ST_F3       = 5'd12,
        ST_F4       = 5'd13,
        ST_N1       = 5'd14,
        ST_N2       = 5'd15,
        ST_N3       = 5'd16,
        ST_ZERO     = 5'd17,
        ST_DOT      = 5'd18,
        ST_FRAC     = 5'd19,
        ST_EXP      = 5'd20,
        ST_EXP_DIG  = 5'd21,
        ST_EXP_SIGN = 5'd22,
        ST_MINUS    = 5'd23,
        ST_INT      = 5'd24
    } state_t;

    // Input register
    logic   in_valid_reg;
    char_t  ch_reg;

    // Scanner state
    state_t state_reg, state_next;

    // Output register and pending second result
    logic   out_valid_reg;
    event_t out_event_reg;
    char_t  out_char_reg;
    logic   out_last_reg;
    logic   pend_valid_reg;
    event_t pend_event_reg;

    // Decode results
    event_t ev_a, ev_b;
    logic   carry_char;
    logic   two_res;

    logic   out_free;
    logic   advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free && !pend_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    // Character decode against the scanner state
    always_comb
    begin
        ev_a       = EV_ILLEGAL;
        ev_b       = EV_NONE;
        carry_char = 1'b0;
        two_res    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_GENERAL:
            begin
                if (is_ws(ch_reg))
                    ev_a = EV_NONE;
                else if (ch_reg == CH_QUOTE)
                begin
                    ev_a = EV_STR_START;
                    state_next = ST_STRING;
                end
                else if (ch_reg == CH_LBRACE)
                    ev_a = EV_OPEN_OBJ;
                else if (ch_reg == CH_RBRACE)
                    ev_a = EV_CLOSE_OBJ;
                else if (ch_reg == CH_LBRACKET)
                    ev_a = EV_OPEN_ARR;
                else if (ch_reg == CH_RBRACKET)
                    ev_a = EV_CLOSE_ARR;
                else if (ch_reg == CH_COLON)
                    ev_a = EV_COLON;
                else if (ch_reg == CH_COMMA)
                    ev_a = EV_COMMA;
                else if (ch_reg == CH_LC_T)
                begin
                    ev_a = EV_NONE;
                    state_next = ST_T1;
                end
                else if (ch_reg == CH_LC_F)
                begin
                    ev_a = EV_NONE;
                    state_next = ST_F1;
                end
                else if (ch_reg == CH_LC_N)
                begin
                    ev_a = EV_NONE;
                    state_next = ST_N1;
                end
                else if (ch_reg == CH_ZERO)
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_ZERO;
                end
                else if (is_digit(ch_reg))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_INT;
                end
                else if (ch_reg == CH_MINUS)
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_MINUS;
                end
            end
            ST_STRING:
            begin
                if (ch_reg == CH_QUOTE)
                begin
                    ev_a = EV_STR_END;
                    state_next = ST_GENERAL;
                end
                else
                begin
                    ev_a = EV_STR_CHAR;
                    carry_char = 1'b1;
                    if (ch_reg == CH_BSLASH)
                        state_next = ST_ESCAPE;
                end
            end
            ST_ESCAPE:
            begin
                if (ch_reg inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F,
                                   CH_LC_N, CH_LC_R, CH_LC_T})
                begin
                    ev_a = EV_STR_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_STRING;
                end
                else if (ch_reg == CH_LC_U)
                begin
                    ev_a = EV_STR_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_HEX1;
                end
            end
            ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4:
            begin
                if (is_hex(ch_reg))
                begin
                    ev_a = EV_STR_CHAR;
                    carry_char = 1'b1;
                    state_next = (state_reg == ST_HEX4) ? ST_STRING
                                                        : state_t'(state_reg + 5'd1);
                end
            end
            ST_T1, ST_T2, ST_T3, ST_F1, ST_F2, ST_F3, ST_F4, ST_N1, ST_N2, ST_N3:
            begin
                if (ch_reg == lit_expect(state_reg))
                begin
                    if (state_reg == ST_T3)
                    begin
                        ev_a = EV_TRUE;
                        state_next = ST_GENERAL;
                    end
                    else if (state_reg == ST_F4)
                    begin
                        ev_a = EV_FALSE;
                        state_next = ST_GENERAL;
                    end
                    else if (state_reg == ST_N3)
                    begin
                        ev_a = EV_NULL;
                        state_next = ST_GENERAL;
                    end
                    else
                    begin
                        ev_a = EV_NONE;
                        state_next = state_t'(state_reg + 5'd1);
                    end
                end
            end
            ST_ZERO, ST_FRAC, ST_EXP_DIG, ST_INT:
            begin
                if (is_ws(ch_reg) || (ch_reg inside {CH_RBRACE, CH_RBRACKET, CH_COMMA}))
                begin
                    // Number ends; a structural terminator adds its own event
                    ev_a = EV_NUM_END;
                    state_next = ST_GENERAL;
                    if (ch_reg == CH_RBRACE)
                    begin
                        ev_b = EV_CLOSE_OBJ;
                        two_res = 1'b1;
                    end
                    else if (ch_reg == CH_RBRACKET)
                    begin
                        ev_b = EV_CLOSE_ARR;
                        two_res = 1'b1;
                    end
                    else if (ch_reg == CH_COMMA)
                    begin
                        ev_b = EV_COMMA;
                        two_res = 1'b1;
                    end
                end
                else if (is_digit(ch_reg) && (state_reg != ST_ZERO))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                end
                else if ((ch_reg == CH_DOT)
                         && ((state_reg == ST_ZERO) || (state_reg == ST_INT)))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_DOT;
                end
                else if (((ch_reg == CH_LC_E) || (ch_reg == CH_UC_E))
                         && (state_reg != ST_EXP_DIG))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_EXP;
                end
            end
            ST_DOT:
            begin
                if (is_digit(ch_reg))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_FRAC;
                end
            end
            ST_EXP:
            begin
                if ((ch_reg == CH_PLUS) || (ch_reg == CH_MINUS))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_EXP_SIGN;
                end
                else if (is_digit(ch_reg))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_EXP_DIG;
                end
            end
            ST_EXP_SIGN:
            begin
                if (is_digit(ch_reg))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_EXP_DIG;
                end
            end
            ST_MINUS:
            begin
                if (ch_reg == CH_ZERO)
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_ZERO;
                end
                else if (is_digit(ch_reg))
                begin
                    ev_a = EV_NUM_CHAR;
                    carry_char = 1'b1;
                    state_next = ST_INT;
                end
            end
            default:
            begin
                // Unused codes recover to the general state
                ev_a = EV_ILLEGAL;
                state_next = ST_GENERAL;
            end
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ch_reg <= s_tdata[CH_W-1:0];
    end

    // Scanner state moves when a character leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_GENERAL;
        else if (advance)
            state_reg <= state_next;
    end

    // Output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= in_valid_reg;
                pend_valid_reg <= in_valid_reg && two_res;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_event_reg <= pend_event_reg;
                out_char_reg  <= '0;
                out_last_reg  <= 1'b1;
            end
            else if (in_valid_reg)
            begin
                out_event_reg  <= ev_a;
                out_char_reg   <= carry_char ? ch_reg : '0;
                out_last_reg   <= !two_res;
                pend_event_reg <= ev_b;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_char_reg, out_event_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    `JTS_ASSERT_SAME(a_pend_behind_first, clk, rst_n, pend_valid_reg,
        out_valid_reg && !m_tlast, "second result pending without an open first result")
    `JTS_ASSERT_NEXT(a_two_sets_pend, clk, rst_n, advance && two_res,
        pend_valid_reg, "two-result character did not queue its second result")
    `JTS_ASSERT_SAME(a_no_accept_pending, clk, rst_n, pend_valid_reg,
        !advance, "character left the input register while a result was pending")
    `JTS_ASSERT_SAME(a_content_zero, clk, rst_n,
        out_valid_reg && (out_event_reg != EV_STR_CHAR) && (out_event_reg != EV_NUM_CHAR),
        out_char_reg == '0, "content set on an event that carries no character")

endmodule

FILE: tb/token_checker.sv
`timescale 1ns / 1ps

module token_checker
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          error_count,
    output int          pending
);

    // Scanner states, with the same codes as the block's states
    typedef enum logic [4:0] {
        SC_GENERAL  = 5'd0,
        SC_STRING   = 5'd1,
        SC_ESCAPE   = 5'd2,
        SC_HEX1     = 5'd3,
        SC_HEX2     = 5'd4,
        SC_HEX3     = 5'd5,
        SC_HEX4     = 5'd6,
        SC_T        = 5'd7,
        SC_TR       = 5'd8,
        SC_TRU      = 5'd9,
        SC_F        = 5'd10,
        SC_FA       = 5'd11,
        SC_FAL      = 5'd12,
        SC_FALS     = 5'd13,
        SC_N        = 5'd14,
        SC_NU       = 5'd15,
        SC_NUL      = 5'd16,
        SC_ZERO     = 5'd17,
        SC_DOT      = 5'd18,
        SC_FRAC     = 5'd19,
        SC_EXP      = 5'd20,
        SC_EXP_DIG  = 5'd21,
        SC_EXP_SIGN = 5'd22,
        SC_MINUS    = 5'd23,
        SC_INT      = 5'd24
    } scan_state_t;

    typedef struct {
        event_t ev;
        char_t  content;
        logic   last;
    } token_t;

    token_t      expected_tokens[$];
    scan_state_t scan_st = SC_GENERAL;
    int          fails = 0;

    assign error_count = fails;

    function automatic logic blank_char(input char_t c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic dec_char(input char_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic hex_char_ok(input char_t c);
        return dec_char(c) || (c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    // Letter the literal states wait for next
    function automatic char_t literal_letter(input scan_state_t st);
        case (st)
            SC_T:    return CH_LC_R;
            SC_TR:   return CH_LC_U;
            SC_TRU:  return CH_LC_E;
            SC_F:    return CH_LC_A;
            SC_FA:   return CH_LC_L;
            SC_FAL:  return CH_LC_S;
            SC_FALS: return CH_LC_E;
            SC_N:    return CH_LC_U;
            SC_NU:   return CH_LC_L;
            default: return CH_LC_L;
        endcase
    endfunction

    task automatic emit(input event_t ev, input char_t c);
        token_t t;
        t.ev      = ev;
        t.content = c;
        t.last    = 1'b0;
        expected_tokens.push_back(t);
    endtask

    // Token events caused by one character; an illegal character keeps the state
    task automatic predict_tokens(input char_t c);
        scan_state_t nxt;
        token_t      tok;
        nxt = scan_st;
        case (scan_st)
            SC_GENERAL:
            begin
                if (blank_char(c)) emit(EV_NONE, '0);
                else if (c == CH_QUOTE) begin emit(EV_STR_START, '0); nxt = SC_STRING; end
                else if (c == CH_LBRACE) emit(EV_OPEN_OBJ, '0);
                else if (c == CH_RBRACE) emit(EV_CLOSE_OBJ, '0);
                else if (c == CH_LBRACKET) emit(EV_OPEN_ARR, '0);
                else if (c == CH_RBRACKET) emit(EV_CLOSE_ARR, '0);
                else if (c == CH_COLON) emit(EV_COLON, '0);
                else if (c == CH_COMMA) emit(EV_COMMA, '0);
                else if (c == CH_LC_T) begin emit(EV_NONE, '0); nxt = SC_T; end
                else if (c == CH_LC_F) begin emit(EV_NONE, '0); nxt = SC_F; end
                else if (c == CH_LC_N) begin emit(EV_NONE, '0); nxt = SC_N; end
                else if (c == CH_ZERO) begin emit(EV_NUM_CHAR, c); nxt = SC_ZERO; end
                else if (dec_char(c)) begin emit(EV_NUM_CHAR, c); nxt = SC_INT; end
                else if (c == CH_MINUS) begin emit(EV_NUM_CHAR, c); nxt = SC_MINUS; end
                else emit(EV_ILLEGAL, '0);
            end
            SC_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    emit(EV_STR_END, '0);
                    nxt = SC_GENERAL;
                end
                else
                begin
                    emit(EV_STR_CHAR, c);
                    if (c == CH_BSLASH) nxt = SC_ESCAPE;
                end
            end
            SC_ESCAPE:
            begin
                if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LC_B ||
                    c == CH_LC_F || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T)
                begin
                    emit(EV_STR_CHAR, c);
                    nxt = SC_STRING;
                end
                else if (c == CH_LC_U)
                begin
                    emit(EV_STR_CHAR, c);
                    nxt = SC_HEX1;
                end
                else emit(EV_ILLEGAL, '0);
            end
            SC_HEX1, SC_HEX2, SC_HEX3, SC_HEX4:
            begin
                if (hex_char_ok(c))
                begin
                    emit(EV_STR_CHAR, c);
                    nxt = (scan_st == SC_HEX4) ? SC_STRING : scan_state_t'(scan_st + 5'd1);
                end
                else emit(EV_ILLEGAL, '0);
            end
            SC_T, SC_TR, SC_TRU, SC_F, SC_FA, SC_FAL, SC_FALS, SC_N, SC_NU, SC_NUL:
            begin
                if (c != literal_letter(scan_st)) emit(EV_ILLEGAL, '0);
                else if (scan_st == SC_TRU) begin emit(EV_TRUE, '0); nxt = SC_GENERAL; end
                else if (scan_st == SC_FALS) begin emit(EV_FALSE, '0); nxt = SC_GENERAL; end
                else if (scan_st == SC_NUL) begin emit(EV_NULL, '0); nxt = SC_GENERAL; end
                else
                begin
                    emit(EV_NONE, '0);
                    nxt = scan_state_t'(scan_st + 5'd1);
                end
            end
            // States where a number may end
            SC_ZERO, SC_FRAC, SC_EXP_DIG, SC_INT:
            begin
                if (blank_char(c) || c == CH_RBRACE || c == CH_RBRACKET || c == CH_COMMA)
                begin
                    emit(EV_NUM_END, '0);
                    if (c == CH_RBRACE) emit(EV_CLOSE_OBJ, '0);
                    else if (c == CH_RBRACKET) emit(EV_CLOSE_ARR, '0);
                    else if (c == CH_COMMA) emit(EV_COMMA, '0);
                    nxt = SC_GENERAL;
                end
                else if (dec_char(c) && scan_st != SC_ZERO) emit(EV_NUM_CHAR, c);
                else if (c == CH_DOT && (scan_st == SC_ZERO || scan_st == SC_INT))
                begin
                    emit(EV_NUM_CHAR, c);
                    nxt = SC_DOT;
                end
                else if ((c == CH_LC_E || c == CH_UC_E) && scan_st != SC_EXP_DIG)
                begin
                    emit(EV_NUM_CHAR, c);
                    nxt = SC_EXP;
                end
                else emit(EV_ILLEGAL, '0);
            end
            SC_DOT:
            begin
                if (dec_char(c)) begin emit(EV_NUM_CHAR, c); nxt = SC_FRAC; end
                else emit(EV_ILLEGAL, '0);
            end
            SC_EXP:
            begin
                if (c == CH_PLUS || c == CH_MINUS) begin emit(EV_NUM_CHAR, c); nxt = SC_EXP_SIGN; end
                else if (dec_char(c)) begin emit(EV_NUM_CHAR, c); nxt = SC_EXP_DIG; end
                else emit(EV_ILLEGAL, '0);
            end
            SC_EXP_SIGN:
            begin
                if (dec_char(c)) begin emit(EV_NUM_CHAR, c); nxt = SC_EXP_DIG; end
                else emit(EV_ILLEGAL, '0);
            end
            SC_MINUS:
            begin
                if (c == CH_ZERO) begin emit(EV_NUM_CHAR, c); nxt = SC_ZERO; end
                else if (dec_char(c)) begin emit(EV_NUM_CHAR, c); nxt = SC_INT; end
                else emit(EV_ILLEGAL, '0);
            end
            default:
            begin
                emit(EV_ILLEGAL, '0);
                nxt = SC_GENERAL;
            end
        endcase
        // the final event of the character carries last
        tok = expected_tokens.pop_back();
        tok.last = 1'b1;
        expected_tokens.push_back(tok);
        scan_st = nxt;
    endtask

    // Compare results first, then predict from the request taken at the same edge
    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
        begin
            scan_st = SC_GENERAL;
            expected_tokens.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fails++;
                    $display("%0t: expected none, actual ev=%0d char=%h last=%b",
                             $time, m_tdata[3:0], m_tdata[24:4], m_tlast);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tdata[3:0] !== want.ev || m_tdata[24:4] !== want.content ||
                        m_tlast !== want.last)
                    begin
                        fails++;
                        $display("%0t: exp ev=%0d char=%h last=%b, act ev=%0d char=%h last=%b",
                                 $time, want.ev, want.content, want.last,
                                 m_tdata[3:0], m_tdata[24:4], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_tokens(s_tdata[CH_W-1:0]);
            pending <= expected_tokens.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jts_pkg::*;

    localparam int RANDOM_CHARS = 400;
    localparam int N_DIRECTED   = 28;
    localparam int TIMEOUT_NS   = 4_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [20:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [3:0] event_res, [24:4] content_char
    logic        m_tlast;

    int          error_count;
    int          pending_results;
    int          sent_count = 0;
    int          hold_left = 0;
    logic [9:0]  rx_cycle = '0;
    char_t       stim_q[$];

    // Object with a string holding a control char, the top code point and a
    // hex escape; an array with -0e5 closed by a comma, 7 closed by a space, true
    char_t directed_chars [N_DIRECTED] = '{
        21'h0, CH_LBRACE, CH_QUOTE, 21'h01, 21'h10FFFF, CH_BSLASH, CH_LC_U,
        CH_ZERO, CH_UC_F, CH_LC_A, CH_NINE, CH_QUOTE, CH_COLON, CH_LBRACKET,
        CH_MINUS, CH_ZERO, CH_LC_E, CH_ZERO + 21'd5, CH_COMMA, CH_ZERO + 21'd7,
        CH_SPACE, CH_COMMA, CH_LC_T, CH_LC_R, CH_LC_U, CH_LC_E, CH_RBRACKET,
        CH_RBRACE
    };

    json_token_scanner u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    token_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .pending     (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output stalls: mostly short, a few long, and calm stretches with none
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 10'd1;
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!(rx_cycle[9] && rx_cycle[8]) && $urandom_range(3) == 0)
                hold_left <= ($urandom_range(7) == 0) ? $urandom_range(40, 10)
                                                      : $urandom_range(3, 1);
        end
    end

    function automatic int pick_gap();
        if ((sent_count / 64) % 4 == 3)
            return 0;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7:       return $urandom_range(3, 1);
            8:             return $urandom_range(8, 4);
            default:       return $urandom_range(40, 15);
        endcase
    endfunction

    function automatic char_t pick_ws();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Any code point, leaning toward printable ASCII
    function automatic char_t any_char();
        case ($urandom_range(3))
            0:       return char_t'($urandom_range(32'h10FFFF));
            1:       return char_t'($urandom_range(32'h1F));
            default: return char_t'($urandom_range(32'h7E, 32'h20));
        endcase
    endfunction

    function automatic char_t pick_digit(input int lo);
        return char_t'(CH_ZERO + $urandom_range(9, lo));
    endfunction

    function automatic char_t pick_hex();
        case ($urandom_range(2))
            0:       return pick_digit(0);
            1:       return char_t'(CH_LC_A + $urandom_range(5));
            default: return char_t'(CH_UC_A + $urandom_range(5));
        endcase
    endfunction

    function automatic char_t pick_escape();
        case ($urandom_range(7))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_LC_B;
            4:       return CH_LC_F;
            5:       return CH_LC_N;
            6:       return CH_LC_R;
            default: return CH_LC_T;
        endcase
    endfunction

    // String with plain, control, wide, escaped and hex-escaped content
    function automatic void push_string();
        char_t c;
        stim_q.push_back(CH_QUOTE);
        repeat ($urandom_range(6))
        begin
            case ($urandom_range(7))
                0:
                begin
                    stim_q.push_back(CH_BSLASH);
                    stim_q.push_back(($urandom_range(7) == 0) ? any_char() : pick_escape());
                end
                1:
                begin
                    stim_q.push_back(CH_BSLASH);
                    stim_q.push_back(CH_LC_U);
                    repeat (4)
                    begin
                        if ($urandom_range(15) == 0)
                            stim_q.push_back(any_char());
                        stim_q.push_back(pick_hex());
                    end
                end
                default:
                begin
                    c = any_char();
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        c = CH_LC_A;
                    stim_q.push_back(c);
                end
            endcase
        end
        stim_q.push_back(CH_QUOTE);
    endfunction

    // Number with optional sign, fraction and exponent, then a terminator
    function automatic void push_number();
        if ($urandom_range(2) == 0)
            stim_q.push_back(CH_MINUS);
        if ($urandom_range(3) == 0)
            stim_q.push_back(CH_ZERO);
        else
        begin
            stim_q.push_back(pick_digit(1));
            repeat ($urandom_range(3)) stim_q.push_back(pick_digit(0));
        end
        if ($urandom_range(1) == 0)
        begin
            stim_q.push_back(CH_DOT);
            repeat ($urandom_range(3, 1)) stim_q.push_back(pick_digit(0));
        end
        if ($urandom_range(2) == 0)
        begin
            stim_q.push_back($urandom_range(1) ? CH_LC_E : CH_UC_E);
            case ($urandom_range(2))
                0:       stim_q.push_back(CH_PLUS);
                1:       stim_q.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(3, 1)) stim_q.push_back(pick_digit(0));
        end
        if ($urandom_range(9) == 0)
            stim_q.push_back(any_char());
        case ($urandom_range(3))
            0:       stim_q.push_back(pick_ws());
            1:       stim_q.push_back(CH_RBRACE);
            2:       stim_q.push_back(CH_RBRACKET);
            default: stim_q.push_back(CH_COMMA);
        endcase
    endfunction

    // true, false or null, now and then with a stray character inside
    function automatic void push_literal();
        char_t word[$];
        case ($urandom_range(2))
            0:       word = '{CH_LC_T, CH_LC_R, CH_LC_U, CH_LC_E};
            1:       word = '{CH_LC_F, CH_LC_A, CH_LC_L, CH_LC_S, CH_LC_E};
            default: word = '{CH_LC_N, CH_LC_U, CH_LC_L, CH_LC_L};
        endcase
        foreach (word[i])
        begin
            if (i > 0 && $urandom_range(11) == 0)
                stim_q.push_back(any_char());
            stim_q.push_back(word[i]);
        end
    endfunction

    function automatic void push_token();
        case ($urandom_range(19))
            0, 1, 2, 3, 4:
            begin
                case ($urandom_range(5))
                    0:       stim_q.push_back(CH_LBRACE);
                    1:       stim_q.push_back(CH_RBRACE);
                    2:       stim_q.push_back(CH_LBRACKET);
                    3:       stim_q.push_back(CH_RBRACKET);
                    4:       stim_q.push_back(CH_COLON);
                    default: stim_q.push_back(CH_COMMA);
                endcase
            end
            5, 6:           stim_q.push_back(pick_ws());
            7, 8, 9, 10:    push_string();
            11, 12, 13, 14: push_number();
            15, 16, 17:     push_literal();
            default:        repeat ($urandom_range(2, 1)) stim_q.push_back(any_char());
        endcase
    endfunction

    // One request: optional idle gap, then hold until taken
    task automatic send_char(input char_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic send_queued();
        while (stim_q.size() != 0)
            send_char(stim_q.pop_front());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    initial
    begin
        logic paused;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_chars[i])
            stim_q.push_back(directed_chars[i]);
        send_queued();

        while (sent_count < N_DIRECTED + RANDOM_CHARS)
        begin
            push_token();
            send_queued();
            // hold off the sender once until the output side has caught up
            if (!paused && sent_count >= N_DIRECTED + RANDOM_CHARS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
